@@ sv/drsp_pkg.sv @@
// Package: shared types and constants of the drive status reply parser.
`timescale 1ns / 1ps

package drsp_pkg;

  localparam logic [5:0] LONG_BYTE_LIMIT  = 6'd60;
  localparam logic [5:0] SHORT_BYTE_LIMIT = 6'd20;
  localparam int         AXIS_LOW_BIT     = 14;
  localparam int         AXIS_HIGH_BIT    = 15;

  localparam int         LONG_RECORD_LEN  = 10;
  localparam logic [3:0] LONG_REC_LAST    = 4'd10;
  localparam logic [3:0] SHORT_STATUS_LEN = 4'd2;
  localparam logic [3:0] SHORT_PC_LEN     = 4'd4;

  localparam logic [7:0] FILL_ONES  = 8'hFF;
  localparam logic [7:0] FILL_ZEROS = 8'h00;

  localparam logic       KIND_RECORD  = 1'b0;
  localparam logic       KIND_SUMMARY = 1'b1;

  localparam logic       FMT_LONG  = 1'b0;
  localparam logic       FMT_SHORT = 1'b1;

  localparam int         OQ_DEPTH = 4;
  localparam int         OQ_AW    = $clog2(OQ_DEPTH);

  typedef struct packed {
    logic               kind;
    logic [1:0]         axis;
    logic [15:0]        status_word;
    logic               pc_present;
    logic [15:0]        program_counter;
    logic [7:0]         analog_value;
    logic signed [23:0] position;
    logic [15:0]        velocity;
    logic [3:0]         axis_mask;
    logic               framing_error;
    logic               last;
  } res_t;

  // Up to two results per byte; vld1 only ever set together with vld0.
  typedef struct packed {
    logic vld0;
    logic vld1;
    res_t res0;
    res_t res1;
  } res_pair_t;

  function automatic logic [1:0] axis_of(input logic [15:0] status);
    return {status[AXIS_HIGH_BIT], status[AXIS_LOW_BIT]};
  endfunction

endpackage

@@ sv/drsp_parse.sv @@
// Reply state tracking and record decode for one buffered byte.
`timescale 1ns / 1ps

module drsp_parse
  import drsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic       func,
  input  logic [7:0] rx_byte,
  input  logic       first_of_reply,
  input  logic       last_of_reply,
  output res_pair_t  results
);

  logic       skip_r, skip_nxt;
  logic       fmt_r, fmt_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [5:0] skc_r, skc_nxt;
  logic [3:0] mask_r, mask_nxt;
  logic [7:0] rec_r   [LONG_RECORD_LEN];
  logic [7:0] rec_nxt [LONG_RECORD_LEN];

  always_comb begin
    logic [5:0]  limit;
    logic        emit, with_pc, long_f;
    logic [15:0] status;
    logic [1:0]  ax;
    res_t        rec, summ;

    skip_nxt = skip_r;
    fmt_nxt  = fmt_r;
    idx_nxt  = idx_r;
    cnt_nxt  = cnt_r;
    skc_nxt  = skc_r;
    mask_nxt = mask_r;
    rec_nxt  = rec_r;
    emit     = 1'b0;
    with_pc  = 1'b0;
    long_f   = 1'b0;

    if (first_of_reply) begin
      skip_nxt = 1'b1;
      idx_nxt  = '0;
      cnt_nxt  = '0;
      skc_nxt  = '0;
      mask_nxt = '0;
      fmt_nxt  = func;
    end
    limit = (fmt_nxt == FMT_SHORT) ? SHORT_BYTE_LIMIT : LONG_BYTE_LIMIT;

    if (cnt_nxt < limit) begin
      cnt_nxt = cnt_nxt + 6'd1;
      if (skip_nxt && (rx_byte == FILL_ONES || rx_byte == FILL_ZEROS)) begin
        skc_nxt = skc_nxt + 6'd1;
      end else begin
        skip_nxt = 1'b0;
        if (idx_nxt < LONG_REC_LAST) begin
          for (int i = 0; i < LONG_RECORD_LEN; i++) begin
            if (idx_nxt == 4'(i)) rec_nxt[i] = rx_byte;
          end
          idx_nxt = idx_nxt + 4'd1;
        end
        if (fmt_nxt == FMT_LONG) begin
          if (idx_nxt >= LONG_REC_LAST) begin
            emit = 1'b1; with_pc = 1'b1; long_f = 1'b1;
            idx_nxt = '0;
          end
        end else if (idx_nxt == SHORT_STATUS_LEN) begin
          if (axis_of({rec_nxt[0], rec_nxt[1]}) != 2'd0) begin
            emit = 1'b1;
            idx_nxt = '0;
          end
        end else if (idx_nxt >= SHORT_PC_LEN) begin
          emit = 1'b1; with_pc = 1'b1;
          idx_nxt = '0;
        end
      end
    end

    status = {rec_nxt[0], rec_nxt[1]};
    ax     = axis_of(status);
    if (emit) mask_nxt = mask_nxt | (4'd1 << ax);

    rec                 = '0;
    rec.kind            = KIND_RECORD;
    rec.axis            = ax;
    rec.status_word     = status;
    rec.pc_present      = with_pc;
    if (with_pc) rec.program_counter = {rec_nxt[3], rec_nxt[2]};
    if (long_f) begin
      rec.analog_value  = rec_nxt[4];
      rec.position      = {rec_nxt[7], rec_nxt[6], rec_nxt[5]};
      rec.velocity      = {rec_nxt[9], rec_nxt[8]};
    end

    summ               = '0;
    summ.kind          = KIND_SUMMARY;
    summ.axis_mask     = mask_nxt;
    summ.framing_error = (fmt_nxt == FMT_SHORT) ? (skc_nxt != 6'd0) : (skc_nxt != 6'd1);
    summ.last          = 1'b1;

    if (emit) begin
      results.vld0 = go;
      results.vld1 = go && last_of_reply;
      results.res0 = rec;
      results.res1 = summ;
    end else begin
      results.vld0 = go && last_of_reply;
      results.vld1 = 1'b0;
      results.res0 = summ;
      results.res1 = summ;
    end

    if (last_of_reply) begin
      skip_nxt = 1'b1;
      idx_nxt  = '0;
      cnt_nxt  = '0;
      skc_nxt  = '0;
      mask_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b1;
      fmt_r  <= FMT_LONG;
      idx_r  <= '0;
      cnt_r  <= '0;
      skc_r  <= '0;
      mask_r <= '0;
    end else if (go) begin
      skip_r <= skip_nxt;
      fmt_r  <= fmt_nxt;
      idx_r  <= idx_nxt;
      cnt_r  <= cnt_nxt;
      skc_r  <= skc_nxt;
      mask_r <= mask_nxt;
    end
  end

  // record bytes: payload only, written before any read
  always_ff @(posedge clk) begin
    if (go) rec_r <= rec_nxt;
  end

endmodule

@@ sv/drsp_outq.sv @@
// Result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module drsp_outq
  import drsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  res_pair_t push,
  input  logic      pop,
  output logic      room2,
  output logic      not_empty,
  output res_t      head
);

  res_t             mem_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_r, wr_nxt;
  logic [OQ_AW-1:0] rd_r, rd_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;

  assign room2     = (cnt_r <= (OQ_AW+1)'(OQ_DEPTH - 2));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r + OQ_AW'(push.vld0) + OQ_AW'(push.vld1);
    rd_nxt  = rd_r + OQ_AW'(pop);
    cnt_nxt = cnt_r + (OQ_AW+1)'(push.vld0) + (OQ_AW+1)'(push.vld1) - (OQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.vld0) mem_r[wr_r] <= push.res0;
    if (push.vld1) mem_r[wr_r + OQ_AW'(1)] <= push.res1;
  end

endmodule

@@ sv/drive_status_reply_parser_core.sv @@
// Top level: stepper-drive status reply parser, byte in, records and summary out.
// Flow: an accepted request waits in the input register and is decoded once the queue has room;
//   its first result then shows on out_, a second result (summary after a record) after it.
// Throughput: one byte request per cycle while in_stall is low; the four-entry result queue must have room
//   for two results before the buffered byte is decoded.
// Reset: synchronous, active-low rst_n; reply state back to skip phase, long format.
`timescale 1ns / 1ps

module drive_status_reply_parser_core
  import drsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // byte requests
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [7:0]         in_rx_byte,
  input  logic               in_first_of_reply,
  input  logic               in_last_of_reply,
  // result requests
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic [1:0]         out_axis,
  output logic [15:0]        out_status_word,
  output logic               out_pc_present,
  output logic [15:0]        out_program_counter,
  output logic [7:0]         out_analog_value,
  output logic signed [23:0] out_position,
  output logic [15:0]        out_velocity,
  output logic [3:0]         out_axis_mask,
  output logic               out_framing_error,
  output logic               out_last
);

  // Input register: one byte request waiting for decode.
  logic       in_vld_r, in_vld_nxt;
  logic       func_r;
  logic [7:0] byte_r;
  logic       first_r;
  logic       last_r;

  logic       go;       // buffered byte decoded this cycle
  logic       room2;
  logic       q_busy;
  res_pair_t  results;
  res_t       head;

  // Decode only when the queue can absorb a record plus a summary.
  assign go       = in_vld_r && room2;
  assign in_stall = in_vld_r && !room2;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (go) in_vld_nxt = 1'b0;
    if (in_valid && !in_stall) in_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      func_r  <= in_func;
      byte_r  <= in_rx_byte;
      first_r <= in_first_of_reply;
      last_r  <= in_last_of_reply;
    end
  end

  drsp_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .go             (go),
    .func           (func_r),
    .rx_byte        (byte_r),
    .first_of_reply (first_r),
    .last_of_reply  (last_r),
    .results        (results)
  );

  drsp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (results),
    .pop       (q_busy && !out_stall),
    .room2     (room2),
    .not_empty (q_busy),
    .head      (head)
  );

  assign out_valid           = q_busy;
  assign out_kind            = head.kind;
  assign out_axis            = head.axis;
  assign out_status_word     = head.status_word;
  assign out_pc_present      = head.pc_present;
  assign out_program_counter = head.program_counter;
  assign out_analog_value    = head.analog_value;
  assign out_position        = head.position;
  assign out_velocity        = head.velocity;
  assign out_axis_mask       = head.axis_mask;
  assign out_framing_error   = head.framing_error;
  assign out_last            = head.last;

endmodule

@@ sv/drsp_checker.sv @@
// Checker: port-level properties of the reply parser, bound to the top level.
`timescale 1ns / 1ps

module drsp_checker
  import drsp_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [1:0]  out_axis,
  input logic [15:0] out_status_word,
  input logic        out_pc_present,
  input logic [15:0] out_program_counter,
  input logic [3:0]  out_axis_mask,
  input logic        out_framing_error,
  input logic        out_last
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status_word) && $stable(out_kind))
    else $error("stalled result changed");

  a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |-> out_last)
    else $error("summary without last mark");

  a_record_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_RECORD |->
      !out_last && out_axis_mask == 4'd0 && !out_framing_error)
    else $error("record carries summary fields");

  a_summary_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |->
      out_axis == 2'd0 && out_status_word == 16'd0 && !out_pc_present)
    else $error("summary carries record fields");

  a_pc_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pc_present |-> out_program_counter == 16'd0)
    else $error("program counter set without pc_present");

endmodule

bind drive_status_reply_parser_core drsp_checker u_drsp_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_kind            (out_kind),
  .out_axis            (out_axis),
  .out_status_word     (out_status_word),
  .out_pc_present      (out_pc_present),
  .out_program_counter (out_program_counter),
  .out_axis_mask       (out_axis_mask),
  .out_framing_error   (out_framing_error),
  .out_last            (out_last)
);
